### design/skvt_pkg.sv
// ----------------------------------------------------------------------------
// skvt_pkg
// Shared types and constants of the sorted key/value table: pool size,
// index widths, operation codes, controller states and the result record.
// ----------------------------------------------------------------------------
package skvt_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int LINK_W = $clog2(CAPACITY + 1);
  localparam int CNT_W = LINK_W;
  localparam int DATA_W = 32;

  localparam logic [LINK_W-1:0] NIL = LINK_W'(CAPACITY);

  typedef enum logic [1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_LOOKUP = 2'd1,
    FUNC_DELETE = 2'd2,
    FUNC_SPREAD = 2'd3
  } func_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK,
    ST_SPREAD,
    ST_VAL_WR,
    ST_ALLOC_RD,
    ST_ALLOC_WR,
    ST_LINK_WR,
    ST_UNLINK,
    ST_FREE_WR,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic              found;
    logic [DATA_W-1:0] prior_value;
    logic [CNT_W-1:0]  entry_count;
    logic [DATA_W-1:0] spread;
    logic              status;
  } result_t;

endpackage

### design/skvt_ram.sv
// ----------------------------------------------------------------------------
// skvt_ram
// Generic single-write, single-read synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module skvt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/skvt_ctrl.sv
// ----------------------------------------------------------------------------
// skvt_ctrl
// Node pool and list walker: holds keys, values and links in three RAMs,
// walks the sorted list one node per cycle and edits links and free list.
// ----------------------------------------------------------------------------
module skvt_ctrl (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            order_mode,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      in_func,
  input  logic signed [skvt_pkg::DATA_W-1:0] in_key,
  input  logic signed [skvt_pkg::DATA_W-1:0] in_value,
  output logic                            res_valid,
  input  logic                            res_ready,
  output skvt_pkg::result_t               res
);

  skvt_pkg::state_t state, state_next;

  logic [skvt_pkg::IDX_W-1:0]  clr_idx;
  skvt_pkg::func_t             op_func;
  logic signed [skvt_pkg::DATA_W-1:0] op_key;
  logic signed [skvt_pkg::DATA_W-1:0] op_val;
  logic [skvt_pkg::LINK_W-1:0] cur;
  logic [skvt_pkg::LINK_W-1:0] last;
  logic [skvt_pkg::LINK_W-1:0] steps;
  logic [skvt_pkg::LINK_W-1:0] hit;
  logic [skvt_pkg::LINK_W-1:0] hit_link;
  logic [skvt_pkg::LINK_W-1:0] list_head;
  logic [skvt_pkg::LINK_W-1:0] free_head;
  logic [skvt_pkg::CNT_W-1:0]  pair_count;
  logic                        found;
  logic                        status;
  logic [skvt_pkg::DATA_W-1:0] old_val;
  logic signed [skvt_pkg::DATA_W-1:0] vmax;
  logic signed [skvt_pkg::DATA_W-1:0] vmin;

  logic [skvt_pkg::IDX_W-1:0]  rd_addr;
  logic [skvt_pkg::IDX_W-1:0]  wr_addr;
  logic                        key_we;
  logic                        val_we;
  logic                        link_we;
  logic [skvt_pkg::LINK_W-1:0] link_wdata;
  logic [skvt_pkg::DATA_W-1:0] key_rdata;
  logic [skvt_pkg::DATA_W-1:0] val_rdata;
  logic [skvt_pkg::LINK_W-1:0] link_rdata;

  logic accept;
  logic cur_is_node;
  logic step_ok;
  logic keeps;
  logic key_eq;
  logic walk_go;
  logic signed [skvt_pkg::DATA_W-1:0] node_val;

  skvt_ram #(.WIDTH(skvt_pkg::DATA_W), .DEPTH(skvt_pkg::CAPACITY)) u_keys (
    .clk(clk), .we(key_we), .waddr(wr_addr), .wdata(op_key),
    .raddr(rd_addr), .rdata(key_rdata)
  );

  skvt_ram #(.WIDTH(skvt_pkg::DATA_W), .DEPTH(skvt_pkg::CAPACITY)) u_values (
    .clk(clk), .we(val_we), .waddr(wr_addr), .wdata(op_val),
    .raddr(rd_addr), .rdata(val_rdata)
  );

  skvt_ram #(.WIDTH(skvt_pkg::LINK_W), .DEPTH(skvt_pkg::CAPACITY)) u_links (
    .clk(clk), .we(link_we), .waddr(wr_addr), .wdata(link_wdata),
    .raddr(rd_addr), .rdata(link_rdata)
  );

  assign accept = in_valid && in_ready;
  assign cur_is_node = cur < skvt_pkg::NIL;
  assign step_ok = steps < skvt_pkg::NIL;
  assign key_eq = key_rdata == op_key;
  assign keeps = order_mode ? ($signed(key_rdata) >= op_key)
                            : ($signed(key_rdata) <= op_key);
  assign walk_go = cur_is_node && step_ok && keeps;
  assign node_val = $signed(val_rdata);

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      skvt_pkg::ST_CLEAR: begin
        if (clr_idx == skvt_pkg::IDX_W'(skvt_pkg::CAPACITY - 1)) begin
          state_next = skvt_pkg::ST_IDLE;
        end
      end
      skvt_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = (skvt_pkg::func_t'(in_func) == skvt_pkg::FUNC_SPREAD)
                       ? skvt_pkg::ST_SPREAD : skvt_pkg::ST_WALK;
        end
      end
      skvt_pkg::ST_WALK: begin
        if (walk_go && key_eq) begin
          unique case (op_func)
            skvt_pkg::FUNC_INSERT: state_next = skvt_pkg::ST_VAL_WR;
            skvt_pkg::FUNC_DELETE: state_next = skvt_pkg::ST_UNLINK;
            default:               state_next = skvt_pkg::ST_RESP;
          endcase
        end else if (!walk_go) begin
          if (op_func == skvt_pkg::FUNC_INSERT && free_head < skvt_pkg::NIL) begin
            state_next = skvt_pkg::ST_ALLOC_RD;
          end else begin
            state_next = skvt_pkg::ST_RESP;
          end
        end
      end
      skvt_pkg::ST_SPREAD: begin
        if (!(cur_is_node && step_ok)) begin
          state_next = skvt_pkg::ST_RESP;
        end
      end
      skvt_pkg::ST_VAL_WR:   state_next = skvt_pkg::ST_RESP;
      skvt_pkg::ST_ALLOC_RD: state_next = skvt_pkg::ST_ALLOC_WR;
      skvt_pkg::ST_ALLOC_WR: begin
        state_next = (last == skvt_pkg::NIL) ? skvt_pkg::ST_RESP : skvt_pkg::ST_LINK_WR;
      end
      skvt_pkg::ST_LINK_WR:  state_next = skvt_pkg::ST_RESP;
      skvt_pkg::ST_UNLINK:   state_next = skvt_pkg::ST_FREE_WR;
      skvt_pkg::ST_FREE_WR:  state_next = skvt_pkg::ST_RESP;
      skvt_pkg::ST_RESP: begin
        if (res_ready) begin
          state_next = skvt_pkg::ST_IDLE;
        end
      end
      default: state_next = skvt_pkg::ST_IDLE;
    endcase
  end

  // Memory ports and handshake outputs.
  always_comb begin
    in_ready = 1'b0;
    res_valid = 1'b0;
    rd_addr = cur[skvt_pkg::IDX_W-1:0];
    wr_addr = hit[skvt_pkg::IDX_W-1:0];
    key_we = 1'b0;
    val_we = 1'b0;
    link_we = 1'b0;
    link_wdata = free_head;
    unique case (state)
      skvt_pkg::ST_CLEAR: begin
        wr_addr = clr_idx;
        link_we = 1'b1;
        link_wdata = skvt_pkg::LINK_W'(clr_idx) + skvt_pkg::LINK_W'(1);
      end
      skvt_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        rd_addr = list_head[skvt_pkg::IDX_W-1:0];
      end
      skvt_pkg::ST_WALK, skvt_pkg::ST_SPREAD: begin
        rd_addr = link_rdata[skvt_pkg::IDX_W-1:0];
      end
      skvt_pkg::ST_VAL_WR: begin
        val_we = 1'b1;
      end
      skvt_pkg::ST_ALLOC_RD: begin
        rd_addr = free_head[skvt_pkg::IDX_W-1:0];
      end
      skvt_pkg::ST_ALLOC_WR: begin
        wr_addr = free_head[skvt_pkg::IDX_W-1:0];
        key_we = 1'b1;
        val_we = 1'b1;
        link_we = 1'b1;
        link_wdata = cur;
      end
      skvt_pkg::ST_LINK_WR: begin
        wr_addr = last[skvt_pkg::IDX_W-1:0];
        link_we = 1'b1;
        link_wdata = hit;
      end
      skvt_pkg::ST_UNLINK: begin
        wr_addr = last[skvt_pkg::IDX_W-1:0];
        link_we = last != skvt_pkg::NIL;
        link_wdata = hit_link;
      end
      skvt_pkg::ST_FREE_WR: begin
        link_we = 1'b1;
        link_wdata = free_head;
      end
      skvt_pkg::ST_RESP: begin
        res_valid = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    res.found = found;
    res.prior_value = old_val;
    res.entry_count = pair_count;
    res.spread = (op_func == skvt_pkg::FUNC_SPREAD && found)
                 ? skvt_pkg::DATA_W'(vmax - vmin) : '0;
    res.status = status;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= skvt_pkg::ST_CLEAR;
      clr_idx <= '0;
      list_head <= skvt_pkg::NIL;
      free_head <= '0;
      pair_count <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        skvt_pkg::ST_CLEAR: begin
          clr_idx <= clr_idx + skvt_pkg::IDX_W'(1);
        end
        skvt_pkg::ST_IDLE: begin
          if (accept) begin
            op_func <= skvt_pkg::func_t'(in_func);
            op_key <= in_key;
            op_val <= in_value;
            cur <= list_head;
            last <= skvt_pkg::NIL;
            steps <= '0;
            found <= (skvt_pkg::func_t'(in_func) == skvt_pkg::FUNC_SPREAD)
                     && (list_head < skvt_pkg::NIL);
            status <= 1'b0;
            old_val <= '0;
            vmax <= {1'b1, {(skvt_pkg::DATA_W-1){1'b0}}};
            vmin <= {1'b0, {(skvt_pkg::DATA_W-1){1'b1}}};
          end
        end
        skvt_pkg::ST_WALK: begin
          if (walk_go && key_eq) begin
            hit <= cur;
            hit_link <= link_rdata;
            old_val <= val_rdata;
            found <= 1'b1;
          end else if (walk_go) begin
            last <= cur;
            cur <= link_rdata;
            steps <= steps + skvt_pkg::LINK_W'(1);
          end else begin
            if (!cur_is_node) begin
              cur <= skvt_pkg::NIL;
            end
            if (op_func == skvt_pkg::FUNC_INSERT && free_head >= skvt_pkg::NIL) begin
              status <= 1'b1;
            end
          end
        end
        skvt_pkg::ST_SPREAD: begin
          if (cur_is_node && step_ok) begin
            if (node_val > vmax) begin
              vmax <= node_val;
            end
            if (node_val < vmin) begin
              vmin <= node_val;
            end
            cur <= link_rdata;
            steps <= steps + skvt_pkg::LINK_W'(1);
          end
        end
        skvt_pkg::ST_ALLOC_WR: begin
          hit <= free_head;
          free_head <= link_rdata;
          pair_count <= pair_count + skvt_pkg::CNT_W'(1);
          if (last == skvt_pkg::NIL) begin
            list_head <= free_head;
          end
        end
        skvt_pkg::ST_UNLINK: begin
          if (last == skvt_pkg::NIL) begin
            list_head <= hit_link;
          end
        end
        skvt_pkg::ST_FREE_WR: begin
          free_head <= hit;
          if (pair_count != '0) begin
            pair_count <= pair_count - skvt_pkg::CNT_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    pair_count <= skvt_pkg::CNT_W'(skvt_pkg::CAPACITY))
    else $error("pair count exceeds the pool size");

  a_accept_walks: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == skvt_pkg::ST_WALK || state == skvt_pkg::ST_SPREAD))
    else $error("accepted request did not start a walk");

  a_full_refusal: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.status) |-> (free_head == skvt_pkg::NIL))
    else $error("insert refused while free nodes remain");

  a_empty_consistent: assert property (@(posedge clk) disable iff (rst)
    (state == skvt_pkg::ST_IDLE) |-> ((pair_count == '0) == (list_head == skvt_pkg::NIL)))
    else $error("pair count and list head disagree");

endmodule

### design/sorted_key_value_table.sv
// ----------------------------------------------------------------------------
// sorted_key_value_table
// Map of signed 32-bit keys to signed 32-bit values kept as a sorted linked
// list in a fixed node pool, with an APB register for the sort order.
//
// Requests enter on the in_valid/in_ready channel with func, key and
// new_value. Each request produces exactly one result on the
// out_valid/out_ready channel: found, prior_value, entry_count, spread, status.
// Requests are handled one at a time. A request walks the list one node per
// cycle, since the next node address comes from the link RAM read of the
// current node. Insert, lookup and delete read at most 64 stored nodes, and
// spread always reads every stored node. The result sits in an output
// register, so a new request is accepted in the cycle after the result is
// loaded, even while out_ready is low. A stalled receiver holds the block
// only when the next result is ready to be loaded. After reset the link RAM
// is initialized to the free chain, and in_ready stays low until that is
// done; register writes are taken at any time.
// order_mode lives at byte address 0: 0 ascending, 1 descending.
// ----------------------------------------------------------------------------
module sorted_key_value_table (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [2:0]                        paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        func,
  input  logic signed [skvt_pkg::DATA_W-1:0] key,
  input  logic signed [skvt_pkg::DATA_W-1:0] new_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              found,
  output logic signed [skvt_pkg::DATA_W-1:0] prior_value,
  output logic [skvt_pkg::CNT_W-1:0]        entry_count,
  output logic [skvt_pkg::DATA_W-1:0]       spread,
  output logic                              status
);

  localparam logic [2:0] ADDR_ORDER_MODE = 3'd0;

  logic              order_mode;
  logic              res_valid;
  logic              res_ready;
  skvt_pkg::result_t res;
  skvt_pkg::result_t out_res;

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_ORDER_MODE) ? {31'b0, order_mode} : 32'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      order_mode <= 1'b0;
    end else if (psel && penable && pwrite && paddr == ADDR_ORDER_MODE) begin
      order_mode <= pwdata[0];
    end
  end

  skvt_ctrl u_ctrl (
    .clk(clk),
    .rst(rst),
    .order_mode(order_mode),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_func(func),
    .in_key(key),
    .in_value(new_value),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res(res)
  );

  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res <= res;
    end
  end

  assign found = out_res.found;
  assign prior_value = $signed(out_res.prior_value);
  assign entry_count = out_res.entry_count;
  assign spread = out_res.spread;
  assign status = out_res.status;

endmodule
